[rtl/min_tracking_stack_macros.svh]
// Assertion macros for the min tracking stack
`ifndef MIN_TRACKING_STACK_MACROS_SVH
`define MIN_TRACKING_STACK_MACROS_SVH

// same-cycle implication
`define MTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/mts_pkg.sv]
package mts_pkg;

   localparam int DATA_W              = 32;
   localparam int DEFAULT_STACK_DEPTH = 256;

   typedef enum logic [0:0] {
      FUNC_PUSH = 1'b0,
      FUNC_POP  = 1'b1
   } func_type;

   typedef struct packed {
      func_type                 func;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] priority_req;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] top_value;
      logic signed [DATA_W-1:0] top_priority;
      logic signed [DATA_W-1:0] min_value;
      logic                     is_empty;
      logic                     overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD,
      ST_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic latch;
      logic exec;
      logic load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_pop;
      logic empty;
   } dp_status_type;

endpackage

[rtl/mts_ctrl.sv]
module mts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_valid,
   input  mts_pkg::dp_status_type status,
   output mts_pkg::ctrl_cmd_type  cmd
);

   mts_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         mts_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = mts_pkg::ST_EXEC;
            end
         end
         mts_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            // a real pop must refetch the new tops from memory
            if (status.is_pop && !status.empty) begin
               state_in = mts_pkg::ST_LOAD;
            end else begin
               state_in = mts_pkg::ST_RESP;
            end
         end
         mts_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = mts_pkg::ST_RESP;
         end
         mts_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = mts_pkg::ST_IDLE;
         end
         default: begin
            state_in = mts_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/mts_datapath.sv]
module mts_datapath #(
   parameter int STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mts_pkg::req_type       req_data,
   input  mts_pkg::ctrl_cmd_type  cmd,
   output mts_pkg::dp_status_type status,
   output mts_pkg::rsp_type       rsp_data
);

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int DW     = mts_pkg::DATA_W;

   logic [DW-1:0] value_mem    [STACK_DEPTH];
   logic [DW-1:0] priority_mem [STACK_DEPTH];
   logic [DW-1:0] minimum_mem  [STACK_DEPTH];

   mts_pkg::req_type req_ff;
   logic [CNT_W-1:0] entry_count_ff, entry_count_in;
   logic [CNT_W-1:0] minimum_count_ff, minimum_count_in;
   logic [DW-1:0]    top_value_ff, top_value_in;
   logic [DW-1:0]    top_priority_ff, top_priority_in;
   logic [DW-1:0]    top_min_ff, top_min_in;
   logic             overflow_ff, overflow_in;
   logic [DW-1:0]    rd_value_ff, rd_priority_ff, rd_min_ff;

   logic              is_push, full, empty, push_ok, min_push, pop_ok, min_pop;
   logic [ADDR_W-1:0] wr_addr, min_wr_addr, rd_addr, min_rd_addr;
   logic [CNT_W-1:0]  rd_cnt, min_rd_cnt;

   assign is_push = (req_ff.func == mts_pkg::FUNC_PUSH);
   assign full    = (entry_count_ff == CNT_W'(STACK_DEPTH));
   assign empty   = (entry_count_ff == '0);

   assign push_ok  = cmd.exec && is_push && !full;
   assign min_push = push_ok && ((minimum_count_ff == '0) ||
                     ($signed(req_ff.value) <= $signed(top_min_ff)));
   assign pop_ok   = cmd.exec && !is_push && !empty;
   assign min_pop  = pop_ok && (minimum_count_ff != '0) && (top_min_ff == top_value_ff);

   assign wr_addr     = entry_count_ff[ADDR_W-1:0];
   assign min_wr_addr = minimum_count_ff[ADDR_W-1:0];
   assign rd_cnt      = entry_count_ff - CNT_W'(2);
   assign min_rd_cnt  = min_pop ? (minimum_count_ff - CNT_W'(2))
                                : (minimum_count_ff - CNT_W'(1));
   assign rd_addr     = rd_cnt[ADDR_W-1:0];
   assign min_rd_addr = min_rd_cnt[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (push_ok) begin
         value_mem[wr_addr]    <= req_ff.value;
         priority_mem[wr_addr] <= req_ff.priority_req;
      end
      if (min_push) begin
         minimum_mem[min_wr_addr] <= req_ff.value;
      end
      rd_value_ff    <= value_mem[rd_addr];
      rd_priority_ff <= priority_mem[rd_addr];
      rd_min_ff      <= minimum_mem[min_rd_addr];
   end

   always_comb begin
      entry_count_in   = entry_count_ff;
      minimum_count_in = minimum_count_ff;
      top_value_in     = top_value_ff;
      top_priority_in  = top_priority_ff;
      top_min_in       = top_min_ff;
      overflow_in      = overflow_ff;
      if (cmd.exec) begin
         overflow_in = is_push && full;
      end
      if (push_ok) begin
         entry_count_in  = entry_count_ff + CNT_W'(1);
         top_value_in    = req_ff.value;
         top_priority_in = req_ff.priority_req;
      end
      if (min_push) begin
         minimum_count_in = minimum_count_ff + CNT_W'(1);
         top_min_in       = req_ff.value;
      end
      if (pop_ok) begin
         entry_count_in = entry_count_ff - CNT_W'(1);
      end
      if (min_pop) begin
         minimum_count_in = minimum_count_ff - CNT_W'(1);
      end
      if (cmd.load) begin
         top_value_in    = rd_value_ff;
         top_priority_in = rd_priority_ff;
         top_min_in      = rd_min_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff   <= '0;
         minimum_count_ff <= '0;
         overflow_ff      <= 1'b0;
      end else begin
         entry_count_ff   <= entry_count_in;
         minimum_count_ff <= minimum_count_in;
         overflow_ff      <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff <= req_data;
      end
      top_value_ff    <= top_value_in;
      top_priority_ff <= top_priority_in;
      top_min_ff      <= top_min_in;
   end

   assign status.is_pop = !is_push;
   assign status.empty  = empty;

   always_comb begin
      rsp_data.top_value    = empty ? '0 : $signed(top_value_ff);
      rsp_data.top_priority = empty ? '0 : $signed(top_priority_ff);
      rsp_data.min_value    = (minimum_count_ff == '0) ? '0 : $signed(top_min_ff);
      rsp_data.is_empty     = empty;
      rsp_data.overflow     = overflow_ff;
   end

endmodule

[rtl/min_tracking_stack.sv]
// After acceptance the controller steps through EXEC and then RESP, which raises the
// strobe; a pop that removes an entry also passes through LOAD between them.
// No new request is taken before the strobe has passed; a pop that removes an entry waits
// on the registered memory read that refetches the new top and minimum.
// Reset: synchronous, clears both counts and the controller; stack memories are not cleared.
// The result strobe lasts one cycle and cannot be held off by the receiver.
`include "min_tracking_stack_macros.svh"

module min_tracking_stack #(
   parameter int STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mts_pkg::req_type req_data,
   output logic             rsp_valid,
   output mts_pkg::rsp_type rsp_data
);

   mts_pkg::ctrl_cmd_type  cmd;
   mts_pkg::dp_status_type status;

   mts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   mts_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

   `MTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transfer did not raise busy")
   `MTS_ASSERT_NEXT(a_single_strobe, rsp_valid, !rsp_valid, "result strobe longer than one cycle")
   `MTS_ASSERT_NOW(a_ovf_not_empty, rsp_valid && rsp_data.overflow, !rsp_data.is_empty, "overflow reported on empty stack")
   `MTS_ASSERT_NOW(a_strobe_busy, rsp_valid, busy, "result strobe while idle")

endmodule
